@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the area resize unit.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

@@ rtl/aar_pkg.sv @@
// Types, codes and helpers of the adaptive area resize unit.
// No dependencies.
package aar_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DIM_W      = 9;   // size registers and bin bounds
   localparam int CSR_IDX_W  = 3;
   localparam int PLANE_CFG_W = 3;
   localparam int BIN_Q_W    = 9;   // quotient bits of a bin bound
   localparam int MEAN_Q_W   = 16;  // quotient bits of the mean
   localparam int CNT_W      = 5;

   localparam logic [DIM_W-1:0] OUT_LIMIT = 9'd256;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_COUNT = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DLOAD,
      ST_DIV,
      ST_BIN,
      ST_AREA,
      ST_SUM,
      ST_DRAIN,
      ST_MLOAD,
      ST_MDIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      BIN_ROW_LO,
      BIN_ROW_HI,
      BIN_COL_LO,
      BIN_COL_HI
   } bin_op_type;

   // saturate a size register to 1..hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0)
         r = 9'd1;
      else if (v > hi)
         r = hi;
      else
         r = v;
      return r;
   endfunction

endpackage

@@ rtl/adaptive_area_resize_unit.sv @@
// Adaptive area resize unit: sample store plus bin-average read engine.
// Depends on aar_pkg and assert_macros.svh.
// A write item is stored as it is accepted; a read item runs four bin bound divisions,
// one store read per sample and a mean division, all on the one shared multiplier and
// 1-bit divider. A read outside the configured sizes goes straight to the response.
// One item at a time: new requests are stalled until a read item is done.
// Reset is synchronous: sizes return to 256x256 to 256x256, three planes; the
// sample store is not cleared and holds nothing defined until written.
`include "assert_macros.svh"

module adaptive_area_resize_unit import aar_pkg::*; #(
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_PLANES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [1:0]           req_plane,
   input  logic [7:0]           req_row,
   input  logic [7:0]           req_column,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SAMPLE_W-1:0]  rsp_mean_value,
   output logic                 rsp_range_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int PLANE_SPAN = MAX_HEIGHT * MAX_WIDTH;
   localparam int DEPTH      = MAX_PLANES * PLANE_SPAN;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IH_MAX     = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
   localparam int IW_MAX     = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
   localparam int AREA_MAX   = IH_MAX * IW_MAX;
   localparam int AREA_W     = (AREA_MAX > 1) ? $clog2(AREA_MAX + 1) : 1;
   localparam int SUM_W      = SAMPLE_W + AREA_W;
   localparam int DVD_W      = (SUM_W > 18) ? SUM_W : 18;
   localparam int DVS_W      = (AREA_W > DIM_W) ? AREA_W : DIM_W;
   localparam int PC_W       = ($clog2(MAX_PLANES + 1) > PLANE_CFG_W) ?
                               $clog2(MAX_PLANES + 1) : PLANE_CFG_W;

   localparam logic [DIM_W-1:0] IH_LIM = DIM_W'(IH_MAX);
   localparam logic [DIM_W-1:0] IW_LIM = DIM_W'(IW_MAX);
   localparam logic [PC_W-1:0]  PC_LIM = PC_W'(MAX_PLANES);

   // configuration
   logic [DIM_W-1:0]       in_height_ff, in_width_ff, out_height_ff, out_width_ff;
   logic [PLANE_CFG_W-1:0] plane_count_ff;
   logic [DIM_W-1:0]       ih, iw, oh, ow;
   logic [PC_W-1:0]        pc;

   // sequencer and datapath
   state_type         state_ff, state_in;
   bin_op_type        op_ff, op_in;
   logic [1:0]        plane_ff, plane_in;
   logic [7:0]        row_ff, row_in, col_ff, col_in;
   logic              err_ff, err_in;
   logic [DIM_W-1:0]  r0_ff, r0_in, r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [DIM_W-1:0]  y_ff, y_in, x_ff, x_in;
   logic [17:0]       prod_ff, prod_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] row_addr_ff, row_addr_in, addr_ff, addr_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic              rd_valid_ff, rd_en;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              req_accept, rsp_free, wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DIM_W-1:0]  mul_a, mul_b, n_out, n_in, lim, lo, hi_t;
   logic [DIM_W-1:0]  quo_bin;
   logic [17:0]       bin_dvd;
   logic [DVD_W-1:0]  dvd;
   logic [DVS_W:0]    trial;
   logic [AREA_W-1:0] area;

   logic [SAMPLE_W-1:0] store_mem [DEPTH];

   assign ih = clamp_dim(in_height_ff, IH_LIM);
   assign iw = clamp_dim(in_width_ff, IW_LIM);
   assign oh = clamp_dim(out_height_ff, OUT_LIMIT);
   assign ow = clamp_dim(out_width_ff, OUT_LIMIT);
   always_comb begin
      if (plane_count_ff == '0)
         pc = PC_W'(1);
      else if (PC_W'(plane_count_ff) > PC_LIM)
         pc = PC_LIM;
      else
         pc = PC_W'(plane_count_ff);
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   assign wr_en = req_accept && (req_command == CMD_WRITE) && (PC_W'(req_plane) < pc)
                  && (DIM_W'(req_row) < ih) && (DIM_W'(req_column) < iw);
   assign wr_addr = ADDR_W'(32'(req_plane) * PLANE_SPAN + 32'(req_row) * MAX_WIDTH
                            + 32'(req_column));

   assign area    = AREA_W'(prod_ff);
   assign quo_bin = quo_ff[BIN_Q_W-1:0];
   assign trial   = {rem_ff, quo_ff[DVD_W-1]};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      plane_in     = plane_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      err_in       = err_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      row_addr_in  = row_addr_ff;
      addr_in      = addr_ff;
      sum_in       = rd_valid_ff ? sum_ff + SUM_W'(rd_data_ff) : sum_ff;
      rd_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mean_in  = rsp_mean_ff;
      rsp_err_in   = rsp_err_ff;
      dvd          = '0;

      // operands of the current bin bound
      if (op_ff inside {BIN_ROW_LO, BIN_ROW_HI}) begin
         n_in  = ih;
         n_out = oh;
         mul_a = DIM_W'(row_ff);
         lim   = ih;
         lo    = r0_ff;
      end else begin
         n_in  = iw;
         n_out = ow;
         mul_a = DIM_W'(col_ff);
         lim   = iw;
         lo    = c0_ff;
      end
      if (op_ff inside {BIN_ROW_HI, BIN_COL_HI})
         mul_a = mul_a + 9'd1;
      mul_b = n_in;
      if (state_ff == ST_AREA) begin
         mul_a = r1_ff - r0_ff;
         mul_b = c1_ff - c0_ff;
      end
      if (op_ff inside {BIN_ROW_HI, BIN_COL_HI})
         bin_dvd = prod_ff + 18'(n_out) - 18'd1;
      else
         bin_dvd = prod_ff;
      hi_t = (quo_bin > lim) ? lim : quo_bin;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_command == CMD_READ) begin
               plane_in = req_plane;
               row_in   = req_row;
               col_in   = req_column;
               op_in    = BIN_ROW_LO;
               err_in   = (PC_W'(req_plane) >= pc) || (DIM_W'(req_row) >= oh)
                          || (DIM_W'(req_column) >= ow);
               state_in = err_in ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 18'(mul_a) * 18'(mul_b);
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            dvd      = DVD_W'(bin_dvd);
            rem_in   = DVS_W'(dvd >> BIN_Q_W);
            quo_in   = dvd << (DVD_W - BIN_Q_W);
            dvs_in   = DVS_W'(n_out);
            cnt_in   = CNT_W'(BIN_Q_W);
            state_in = ST_DIV;
         end
         ST_DIV, ST_MDIV: begin
            // restoring divide, one quotient bit a cycle
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = DVS_W'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DVS_W-1:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1)
               state_in = (state_ff == ST_DIV) ? ST_BIN : ST_DONE;
         end
         ST_BIN: begin
            case (op_ff)
               BIN_ROW_LO: begin
                  r0_in = quo_bin;
                  op_in = BIN_ROW_HI;
               end
               BIN_ROW_HI: begin
                  r1_in = (hi_t <= lo) ? lo + 9'd1 : hi_t;
                  op_in = BIN_COL_LO;
               end
               BIN_COL_LO: begin
                  c0_in = quo_bin;
                  op_in = BIN_COL_HI;
               end
               default: begin
                  c1_in = (hi_t <= lo) ? lo + 9'd1 : hi_t;
                  op_in = BIN_ROW_LO;
               end
            endcase
            state_in = (op_ff == BIN_COL_HI) ? ST_AREA : ST_MUL;
         end
         ST_AREA: begin
            prod_in     = 18'(mul_a) * 18'(mul_b);
            row_addr_in = ADDR_W'(32'(plane_ff) * PLANE_SPAN + 32'(r0_ff) * MAX_WIDTH
                                  + 32'(c0_ff));
            addr_in     = row_addr_in;
            y_in        = r0_ff;
            x_in        = c0_ff;
            sum_in      = '0;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            rd_en = 1'b1;
            if (x_ff + 9'd1 == c1_ff) begin
               if (y_ff + 9'd1 == r1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  y_in        = y_ff + 9'd1;
                  x_in        = c0_ff;
                  row_addr_in = row_addr_ff + ADDR_W'(MAX_WIDTH);
                  addr_in     = row_addr_in;
               end
            end else begin
               x_in    = x_ff + 9'd1;
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            // last sample lands in the sum this cycle
            state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            dvd      = DVD_W'(sum_ff) + DVD_W'(area >> 1);
            rem_in   = DVS_W'(dvd >> MEAN_Q_W);
            quo_in   = dvd << (DVD_W - MEAN_Q_W);
            dvs_in   = DVS_W'(area);
            cnt_in   = CNT_W'(MEAN_Q_W);
            state_in = ST_MDIV;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = err_ff ? '0 : quo_ff[MEAN_Q_W-1:0];
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= BIN_ROW_LO;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         in_height_ff   <= 9'd256;
         in_width_ff    <= 9'd256;
         out_height_ff  <= 9'd256;
         out_width_ff   <= 9'd256;
         plane_count_ff <= 3'd3;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IN_HEIGHT:   in_height_ff   <= csr_wdata;
               CSR_IN_WIDTH:    in_width_ff    <= csr_wdata;
               CSR_OUT_HEIGHT:  out_height_ff  <= csr_wdata;
               CSR_OUT_WIDTH:   out_width_ff   <= csr_wdata;
               CSR_PLANE_COUNT: plane_count_ff <= csr_wdata[PLANE_CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff    <= plane_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      err_ff      <= err_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      y_ff        <= y_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      row_addr_ff <= row_addr_in;
      addr_ff     <= addr_in;
      sum_ff      <= sum_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         store_mem[wr_addr] <= req_sample;
      if (rd_en)
         rd_data_ff <= store_mem[addr_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_range_error = rsp_err_ff;

   `ASSERT_PROP(a_div_rem_below, clock, reset,
      (state_ff == ST_DIV || state_ff == ST_MDIV) |-> (rem_ff < dvs_ff),
      "divider remainder not below divisor")
   `ASSERT_PROP(a_scan_in_bin, clock, reset,
      (state_ff == ST_SUM) |-> (y_ff < r1_ff && x_ff < c1_ff && y_ff >= r0_ff),
      "bin scan outside its bounds")
   `ASSERT_PROP(a_rd_in_scan, clock, reset,
      rd_valid_ff |-> (state_ff == ST_SUM || state_ff == ST_DRAIN),
      "store read data outside the bin scan")
   `ASSERT_PROP(a_read_busy, clock, reset,
      (req_accept && req_command == CMD_READ) |=> (state_ff != ST_IDLE),
      "read item accepted without starting work")

endmodule
